// ===== rtl/mpq_pkg.sv =====
// Shared types and codes for the min priority queue core.
package mpq_pkg;

    localparam int unsigned FIELD_VALUE_BITS = 16;
    localparam int unsigned FIELD_COUNT_BITS = 5;
    localparam int unsigned FIELD_STATUS_BITS = 2;

    // Item actions.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [FIELD_STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [FIELD_STATUS_BITS-1:0] ST_FULL       = 2'd1;
    localparam logic [FIELD_STATUS_BITS-1:0] ST_EMPTY_POP  = 2'd2;

    typedef struct packed {
        logic                        action;
        logic [FIELD_VALUE_BITS-1:0] value;
    } t_mpq_in;

    typedef struct packed {
        logic [FIELD_VALUE_BITS-1:0]  removed_value;
        logic [FIELD_VALUE_BITS-1:0]  min_value;
        logic                         is_empty;
        logic [FIELD_COUNT_BITS-1:0]  entry_count;
        logic [FIELD_STATUS_BITS-1:0] status;
    } t_mpq_out;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } t_cell_ctl;

endpackage

// ===== rtl/mpq_cell.sv =====
// One cell of the sorted chain: holds a single value and shifts with its neighbors.
module mpq_cell #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  mpq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occ,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic                  i_left_mv,
    input  logic [VALUE_BITS-1:0] i_right_value,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_mv
);
    import mpq_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // The new value belongs at or before this cell when the cell is empty
    // or holds a larger value; the chain is sorted, so this flag is monotone.
    assign o_mv = ~i_occ | (i_new_value < r_value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.do_rem) begin
            n_value = i_right_value;
        end else if (i_ctl.do_ins && o_mv) begin
            n_value = i_left_mv ? i_left_value : i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/min_priority_queue_core.sv =====
// Min priority queue core: a sorted chain of cells with the minimum in cell zero.
// The result of an item is registered and presented in the cycle after its transfer is accepted.
// Throughput: one item per cycle; each cell compares against the broadcast value in parallel.
// A new item is refused only while a finished result is held by a stalled output.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// stored values are not cleared, since entries beyond the count are never observed.
module min_priority_queue_core #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mpq_pkg::t_mpq_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mpq_pkg::t_mpq_out o_out
);
    import mpq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Per-cell views of the chain. The chain is kept sorted in ascending
    // order over its first r_count cells; cells beyond that hold don't-care data.
    logic [VALUE_BITS-1:0] w_val [CAPACITY];
    logic                  w_mv  [CAPACITY];
    logic                  w_occ [CAPACITY];

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [VALUE_BITS-1:0] r_removed;
    logic [VALUE_BITS-1:0] n_removed;
    logic [1:0]            r_status;
    logic [1:0]            n_status;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic [VALUE_BITS-1:0] w_new_value;
    t_cell_ctl             w_ctl;

    // The input is held off only while a result waits on a stalled output.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_new_value = VALUE_BITS'(i_in.value);

    // An insert into a full queue and a remove from an empty queue leave
    // the chain untouched; only the status reports them.
    assign w_ctl.do_ins = w_accept & (i_in.action == ACT_INSERT) & ~w_full;
    assign w_ctl.do_rem = w_accept & (i_in.action == ACT_REMOVE) & ~w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            mpq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occ         (w_occ[g]),
                .i_new_value   (w_new_value),
                .i_left_value  (w_new_value),
                .i_left_mv     (1'b0),
                .i_right_value ((CAPACITY > 1) ? w_val[(CAPACITY > 1) ? 1 : 0] : w_val[0]),
                .o_value       (w_val[g]),
                .o_mv          (w_mv[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            mpq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occ         (w_occ[g]),
                .i_new_value   (w_new_value),
                .i_left_value  (w_val[g-1]),
                .i_left_mv     (w_mv[g-1]),
                .i_right_value (w_val[g]),
                .o_value       (w_val[g]),
                .o_mv          (w_mv[g])
            );
        end else begin : g_body
            mpq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occ         (w_occ[g]),
                .i_new_value   (w_new_value),
                .i_left_value  (w_val[g-1]),
                .i_left_mv     (w_mv[g-1]),
                .i_right_value (w_val[g+1]),
                .o_value       (w_val[g]),
                .o_mv          (w_mv[g])
            );
        end
    end

    // Count, status and removed value for the item being transferred in.
    always_comb begin
        n_count     = r_count;
        n_removed   = r_removed;
        n_status    = r_status;
        n_out_valid = r_out_valid & i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_removed   = '0;
            n_status    = ST_OK;
            if (i_in.action == ACT_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY_POP;
                end else begin
                    n_removed = w_val[0];
                    n_count   = r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    // The chain and count do not move while a result is held, so the
    // fields read straight from them stay stable under a stall.
    assign o_out_valid         = r_out_valid;
    assign o_out.removed_value = FIELD_VALUE_BITS'(r_removed);
    assign o_out.min_value     = w_empty ? '0 : FIELD_VALUE_BITS'(w_val[0]);
    assign o_out.is_empty      = w_empty;
    assign o_out.entry_count   = FIELD_COUNT_BITS'(r_count);
    assign o_out.status        = r_status;

endmodule
